// ===== rtl/four_direction_sobel_rgb_defines.svh =====
// Assertion macros used by the top module of the four-direction edge filter.
`ifndef FOUR_DIRECTION_SOBEL_RGB_DEFINES_SVH
`define FOUR_DIRECTION_SOBEL_RGB_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FDSR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdsr check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FDSR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fdsr check failed");

`endif

// ===== rtl/fdsr_pkg.sv =====
`default_nettype none

package fdsr_pkg;

	localparam int COL_W   = 10;
	localparam int ROW_W   = 12;
	localparam int HGT_MAX = 4096;

	// Configuration register indexes
	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef logic [7:0]       chan_t;
	typedef logic [23:0]      pix_t;   // red [23:16], green [15:8], blue [7:0]
	typedef pix_t [8:0]       win_t;   // [row*3 + col], rows r-2..r, cols c-2..c
	typedef chan_t [8:0]      lane_win_t;

	// Pending results of one pixel: bit 0 up-left, 1 left on last row,
	// 2 up at row end, 3 current at row end of last row
	typedef struct packed {
		logic [3:0]       mask;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} job_t;

	// Summed kernel weight of window element [dy*3 + dx]
	localparam logic signed [4:0] SOB_W [9] = '{
		5'sd4,  5'sd4,  5'sd2,
		5'sd2,  5'sd0, -5'sd2,
		-5'sd2, -5'sd4, -5'sd4
	};

	// Shift the window by row and column base; elements beyond read as zero
	function automatic win_t shape_window(input win_t w, input logic rb, input logic cb);
		win_t g;
		int   sy;
		int   sx;
		for (int dy = 0; dy < 3; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				sy = dy + int'(rb);
				sx = dx + int'(cb);
				if (sy <= 2 && sx <= 2) begin
					g[dy*3 + dx] = w[sy*3 + sx];
				end else begin
					g[dy*3 + dx] = '0;
				end
			end
		end
		return g;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/four_direction_sobel_rgb.sv =====
// Path: a word passes the front, serialising, shaping, lane-sum and output registers
// before m_tvalid rises. Throughput: one word per cycle while each word causes at
// most one result and m_tready does not stall; a word with several results (row ends,
// last row) holds s_tready low until the serialising stage has sent all but its last.
// Reset: arst_n clears counters, window and valid flags, sets 640 x 480; the line
// stores are not cleared, so no clearing pass is needed.
`default_nettype none

`include "four_direction_sobel_rgb_defines.svh"

module four_direction_sobel_rgb import fdsr_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // red_in, green_in, blue_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // red_edge, green_edge, blue_edge, out_column, out_row, pad
	output logic        m_tlast,    // run_last
	input  logic        cfg_wen,
	input  logic [0:0]  cfg_addr,
	input  logic [12:0] cfg_wdata
);

	logic [10:0]      width_q;
	logic [12:0]      height_q;

	logic             job_valid;
	logic             job_ready;
	job_t             job;
	win_t             job_win;
	pix_t             in_pix;

	logic             s2_v;
	job_t             s2_job;
	win_t             s2_win;
	logic [3:0]       lowbit;
	logic [1:0]       sel;
	logic             one_left;
	logic             emit;
	logic             s2_free;

	logic             s3_v;
	win_t             s3_win;
	logic [COL_W-1:0] s3_col;
	logic [ROW_W-1:0] s3_row;
	logic             s3_last;
	logic             s3_free;

	logic             s4_v;
	logic [COL_W-1:0] s4_col;
	logic [ROW_W-1:0] s4_row;
	logic             s4_last;
	logic             s4_free;

	logic             out_v_q;
	logic [47:0]      tdata_q;
	logic             tlast_q;
	logic             out_free;

	logic [2:0][8:0][7:0] lane_pix;
	logic [2:0][7:0]      lane_mag;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 13'd480;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_WIDTH:  width_q  <= cfg_wdata[10:0];
				REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Repack the word as red high, blue low
	assign in_pix = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

	fdsr_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pix    (in_pix),
		.width_cfg (width_q),
		.height_cfg(height_q),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.job_win   (job_win)
	);

	// Stage readiness, from the output back
	assign out_free = !out_v_q || m_tready;
	assign s4_free  = !s4_v || out_free;
	assign s3_free  = !s3_v || s4_free;

	// Pick the next pending result in order
	assign lowbit   = s2_job.mask & (~s2_job.mask + 4'd1);
	assign one_left = (s2_job.mask & (s2_job.mask - 4'd1)) == 4'd0;
	assign emit     = s2_v && s3_free;
	assign s2_free  = !s2_v || (s3_free && one_left);
	assign job_ready = s2_free;

	always_comb begin
		if (s2_job.mask[0]) begin
			sel = 2'd0;
		end else if (s2_job.mask[1]) begin
			sel = 2'd1;
		end else if (s2_job.mask[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
	end

	// Serialising stage: hold a word's results, drop each as it is sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_free) begin
			s2_v <= job_valid && (job.mask != 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			s2_job <= job;
			s2_win <= job_win;
		end else if (emit) begin
			s2_job.mask <= s2_job.mask & ~lowbit;
		end
	end

	// Window shaping for the chosen result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v <= 1'b0;
		end else if (s3_free) begin
			s3_v <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free) begin
			s3_win  <= shape_window(s2_win, sel[0], sel[1]);
			s3_row  <= sel[0] ? s2_job.row : s2_job.row - ROW_W'(1);
			s3_col  <= sel[1] ? s2_job.col : s2_job.col - COL_W'(1);
			s3_last <= one_left;
		end
	end

	// One lane per colour channel
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		always_comb begin
			for (int k = 0; k < 9; k++) begin
				lane_pix[ch][k] = s3_win[k][23 - 8*ch -: 8];
			end
		end

		fdsr_lane u_lane (
			.clk(clk),
			.en (s4_free),
			.pix(lane_pix[ch]),
			.mag(lane_mag[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_v <= 1'b0;
		end else if (s4_free) begin
			s4_v <= s3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_free) begin
			s4_col  <= s3_col;
			s4_row  <= s3_row;
			s4_last <= s3_last;
		end
	end

	// Merge the lanes into the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s4_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			tdata_q <= {2'b00, s4_row, s4_col, lane_mag[2], lane_mag[1], lane_mag[0]};
			tlast_q <= s4_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	`FDSR_ASSERT_IMP(a_job_nonempty, s2_v, s2_job.mask != 4'd0)
	`FDSR_ASSERT_NXT(a_last_on_final, emit && one_left, s3_v && s3_last)
	`FDSR_ASSERT_NXT(a_job_keeps_rest, emit && !one_left,
		s2_v && (s2_job.mask == $past(s2_job.mask & ~lowbit)))

endmodule

`default_nettype wire

// ===== rtl/fdsr_lane.sv =====
`default_nettype none

module fdsr_lane import fdsr_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  lane_win_t pix,
	output chan_t     mag
);

	logic signed [12:0] acc;
	logic signed [12:0] sum_s4;
	logic        [12:0] abs_v;

	// Weighted sum over the nine window bytes
	always_comb begin
		acc = '0;
		for (int k = 0; k < 9; k++) begin
			acc = acc + $signed({5'b0, pix[k]}) * 13'(SOB_W[k]);
		end
	end

	// Hold the sum for the output stage
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= acc;
		end
	end

	// |trunc(sum/32)| is |sum| >> 5; the peak of 3060/32 stays below 255
	always_comb begin
		abs_v = sum_s4[12] ? 13'(-sum_s4) : 13'(sum_s4);
		mag   = abs_v[12:5];
	end

endmodule

`default_nettype wire

// ===== rtl/fdsr_front.sv =====
`default_nettype none

module fdsr_front import fdsr_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pix_t        in_pix,
	input  logic [10:0] width_cfg,
	input  logic [12:0] height_cfg,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job,
	output win_t        job_win
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [EW-1:0]    w_ext;
	logic [EW-1:0]    w_eff;
	logic [12:0]      h_eff;
	logic             row_end;
	logic             last_row;
	logic             c_ge1;
	logic             r_ge1;
	logic             accept;
	logic             s1_adv;

	logic             s1_v;
	pix_t             px_s1;
	logic [CW-1:0]    addr_s1;
	logic             c0_s1;
	logic             r1_s1;
	logic             r2_s1;
	logic             byp_s1;
	job_t             job_s1;
	logic [47:0]      rd_s1;
	logic [47:0]      wdata_q;
	logic [47:0]      ent;
	logic [47:0]      wr_data;
	pix_t             up1;
	pix_t             up2;
	win_t             window_q;
	win_t             base;
	win_t             win_next;

	// Two stored rows per column: older in [47:24], newer in [23:0]
	logic [47:0] mem [MAX_WIDTH];

	// Clamp frame size
	always_comb begin
		w_ext = EW'(width_cfg);
		if (w_ext == '0) begin
			w_eff = EW'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (height_cfg == '0) begin
			h_eff = 13'd1;
		end else if (height_cfg > 13'(HGT_MAX)) begin
			h_eff = 13'(HGT_MAX);
		end else begin
			h_eff = height_cfg;
		end
	end

	assign row_end  = (EW'(col_q) + EW'(1)) >= w_eff;
	assign last_row = ({1'b0, row_q} + 13'd1) >= h_eff;
	assign c_ge1    = col_q != '0;
	assign r_ge1    = row_q != '0;

	assign in_ready = !s1_v || job_ready;
	assign accept   = in_valid && in_ready;
	assign s1_adv   = s1_v && job_ready;

	// Advance the pixel position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (accept) begin
			s1_v <= 1'b1;
		end else if (s1_adv) begin
			s1_v <= 1'b0;
		end
	end

	// Capture the word and its position flags
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= in_pix;
			addr_s1 <= col_q;
			c0_s1   <= !c_ge1;
			r1_s1   <= r_ge1;
			r2_s1   <= row_q > ROW_W'(1);
			byp_s1  <= s1_adv && (addr_s1 == col_q);
			job_s1  <= '{mask: {row_end && last_row, row_end && r_ge1,
				c_ge1 && last_row, c_ge1 && r_ge1},
				col: COL_W'(col_q), row: row_q};
		end
		if (s1_adv) begin
			wdata_q <= wr_data;
		end
	end

	// Line store: read at acceptance, write back when the word moves on
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[col_q];
		end
		if (s1_adv) begin
			mem[addr_s1] <= wr_data;
		end
	end

	// Forward a write to the same column that the read missed
	assign ent     = byp_s1 ? wdata_q : rd_s1;
	assign wr_data = {ent[23:0], px_s1};
	assign up1     = r1_s1 ? ent[23:0] : '0;
	assign up2     = r2_s1 ? ent[47:24] : '0;

	// Clear at row start, shift left, insert the new column
	always_comb begin
		base     = c0_s1 ? '0 : window_q;
		win_next = base;
		for (int k = 0; k < 3; k++) begin
			win_next[k*3]     = base[k*3 + 1];
			win_next[k*3 + 1] = base[k*3 + 2];
		end
		win_next[2] = up2;
		win_next[5] = up1;
		win_next[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_adv) begin
			window_q <= win_next;
		end
	end

	assign job_valid = s1_v;
	assign job       = job_s1;
	assign job_win   = win_next;

endmodule

`default_nettype wire
